/* hdl/text_terminal_screen_engine_macros.svh */
// ----------------------------------------------------------------------------
// Text terminal screen engine: assertion macros
// Shared concurrent assertion forms for the screen engine RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_SCREEN_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_SCREEN_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tts_pkg.sv */
// ----------------------------------------------------------------------------
// Text terminal screen engine package
// Transfer types and byte codes shared by the screen engine RTL.
// ----------------------------------------------------------------------------
package tts_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [7:0] current_attribute;
        logic       position_error;
    } out_item_t;

    // Item kinds.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Command prefixes.
    localparam logic [7:0] PREFIX_CMD = 8'd1;
    localparam logic [7:0] PREFIX_ESC = 8'd255;

    // Command codes.
    localparam logic [7:0] CMD_CLEAR      = 8'd1;
    localparam logic [7:0] CMD_ATTR       = 8'd2;
    localparam logic [7:0] CMD_SCROLL     = 8'd3;
    localparam logic [7:0] CMD_SCROLL_ALT = 8'd33;
    localparam logic [7:0] CMD_LEFT       = 8'd6;
    localparam logic [7:0] CMD_RIGHT      = 8'd7;
    localparam logic [7:0] CMD_GOTO       = 8'd11;
    localparam logic [7:0] CMD_HOME       = 8'd12;

    localparam logic [7:0] RESET_ATTR = 8'd7;
    localparam logic [7:0] BLANK_CHAR = 8'd0;

endpackage

/* hdl/text_terminal_screen_engine.sv */
// ----------------------------------------------------------------------------
// Text terminal screen engine
// Character and attribute screen driven by a received byte stream.
// ----------------------------------------------------------------------------
// Each transfer on the input channel either feeds one received byte to the
// terminal parser or reads back one screen cell, and each gives exactly one
// result transfer carrying the cursor position, the current attribute, the
// cell that was read (zero for byte items) and a flag for a go-to naming a
// cell off the screen. The screen lives in one RAM of SCREEN_ROWS x
// SCREEN_COLS cells with a single write port, so the cost of an item is set
// by how many cells it touches. A read, a plain byte that stays on the
// screen, an attribute byte or a cursor move touches at most one cell; a
// clear writes every cell; a scroll, and a byte or cursor-right that runs
// off the last cell, copies the rows up one cell per cycle and then blanks
// the last row. After reset the block first writes every cell to blank with
// attribute 7; no input transfer is taken during that sweep. The block
// works on one item at a time, and a new item is taken only once the output
// register is empty or is being emptied in that same cycle.
// ----------------------------------------------------------------------------
`include "text_terminal_screen_engine_macros.svh"

module text_terminal_screen_engine #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tts_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tts_pkg::out_item_t m_data
);

    import tts_pkg::*;

    localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
    localparam int IDX_W      = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int COL_W      = $clog2(SCREEN_COLS);
    // Wide enough for row * SCREEN_COLS + column at any legal size.
    localparam int MUL_W      = 14;

    localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(CELL_COUNT - 1);
    localparam logic [IDX_W-1:0] LAST_ROW_IDX = IDX_W'(CELL_COUNT - SCREEN_COLS);
    localparam logic [IDX_W-1:0] COLS_IDX     = IDX_W'(SCREEN_COLS);
    localparam logic [COL_W-1:0] LAST_COL     = COL_W'(SCREEN_COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [7:0]       COLS_BYTE    = 8'(SCREEN_COLS);
    localparam logic [7:0]       ROWS_BYTE    = 8'(SCREEN_ROWS);

    // Sequencer states.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_DONE   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FILL   = 6'b100000
    } state_t;

    // Byte parser phases.
    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_CMD  = 5'b00010,
        P_ATTR = 5'b00100,
        P_COL  = 5'b01000,
        P_ROW  = 5'b10000
    } phase_t;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [7:0]       cur_attr_reg, cur_attr_next;
    logic [7:0]       def_attr_reg, def_attr_next;
    logic [7:0]       pend_col_reg, pend_col_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             copy_pend_reg, copy_pend_next;
    logic [IDX_W-1:0] copy_waddr_reg, copy_waddr_next;
    logic             init_reg, init_next;
    logic             rd_hit_reg, rd_hit_next;
    logic             perr_reg, perr_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             accept;
    logic             load_res;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [15:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [15:0]      ram_rdata;

    logic [MUL_W-1:0] cur_calc;
    logic [MUL_W-1:0] rd_calc;
    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_in_range;
    logic             goto_ok;

    // Cursor advance, computed once for plain bytes and cursor-right.
    logic [ROW_W-1:0] adv_row;
    logic [COL_W-1:0] adv_col;
    logic             adv_wrap;

    // Screen RAM: one cell per word, attribute in the upper byte.
    tts_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Linear cell indices for the cursor and for a readback request.
    assign cur_calc = MUL_W'(row_reg) * MUL_W'(SCREEN_COLS) + MUL_W'(col_reg);
    assign rd_calc  = MUL_W'(s_data.read_row) * MUL_W'(SCREEN_COLS) + MUL_W'(s_data.read_col);
    assign cur_idx  = cur_calc[IDX_W-1:0];
    assign rd_idx   = rd_calc[IDX_W-1:0];

    assign rd_in_range = ({3'b000, s_data.read_row} < ROWS_BYTE) &&
                         ({1'b0, s_data.read_col} < COLS_BYTE);
    assign goto_ok     = (pend_col_reg < COLS_BYTE) && (s_data.rx_byte < ROWS_BYTE);

    always_comb begin
        adv_wrap = (col_reg == LAST_COL) && (row_reg == LAST_ROW);
        adv_row  = row_reg;
        adv_col  = col_reg + 1'b1;
        if (col_reg == LAST_COL) begin
            adv_col = '0;
            if (!adv_wrap) begin
                adv_row = row_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cur_attr_next   = cur_attr_reg;
        def_attr_next   = def_attr_reg;
        pend_col_next   = pend_col_reg;
        idx_next        = idx_reg;
        copy_pend_next  = copy_pend_reg;
        copy_waddr_next = copy_waddr_reg;
        init_next       = init_reg;
        rd_hit_next     = rd_hit_reg;
        perr_next       = perr_reg;
        load_res        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cur_idx;
        ram_wdata       = {cur_attr_reg, s_data.rx_byte};
        ram_raddr       = idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    perr_next   = 1'b0;
                    rd_hit_next = 1'b0;
                    state_next  = S_DONE;
                    if (s_data.operation == OP_READ) begin
                        // The parser and the screen are left untouched.
                        ram_raddr   = rd_idx;
                        rd_hit_next = rd_in_range;
                        state_next  = S_READ;
                    end else begin
                        case (phase_reg)
                            P_CMD: begin
                                phase_next = P_IDLE;
                                case (s_data.rx_byte)
                                    CMD_CLEAR: begin
                                        // The current attribute becomes the blank one.
                                        def_attr_next = cur_attr_reg;
                                        row_next      = '0;
                                        col_next      = '0;
                                        idx_next      = '0;
                                        state_next    = S_FILL;
                                    end
                                    CMD_ATTR: begin
                                        phase_next = P_ATTR;
                                    end
                                    CMD_SCROLL, CMD_SCROLL_ALT: begin
                                        idx_next       = COLS_IDX;
                                        copy_pend_next = 1'b0;
                                        state_next     = S_SCROLL;
                                    end
                                    CMD_LEFT: begin
                                        if (col_reg != '0) begin
                                            col_next = col_reg - 1'b1;
                                        end else if (row_reg != '0) begin
                                            row_next = row_reg - 1'b1;
                                            col_next = LAST_COL;
                                        end
                                    end
                                    CMD_RIGHT: begin
                                        row_next = adv_row;
                                        col_next = adv_col;
                                        if (adv_wrap) begin
                                            idx_next       = COLS_IDX;
                                            copy_pend_next = 1'b0;
                                            state_next     = S_SCROLL;
                                        end
                                    end
                                    CMD_GOTO: begin
                                        phase_next = P_COL;
                                    end
                                    CMD_HOME: begin
                                        row_next = '0;
                                        col_next = '0;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            P_ATTR: begin
                                cur_attr_next = s_data.rx_byte;
                                phase_next    = P_IDLE;
                            end
                            P_COL: begin
                                pend_col_next = s_data.rx_byte;
                                phase_next    = P_ROW;
                            end
                            P_ROW: begin
                                if (goto_ok) begin
                                    row_next = ROW_W'(s_data.rx_byte);
                                    col_next = COL_W'(pend_col_reg);
                                end else begin
                                    perr_next = 1'b1;
                                end
                                phase_next = P_IDLE;
                            end
                            default: begin
                                if (s_data.rx_byte == PREFIX_CMD ||
                                    s_data.rx_byte == PREFIX_ESC) begin
                                    phase_next = P_CMD;
                                end else begin
                                    ram_we   = 1'b1;
                                    row_next = adv_row;
                                    col_next = adv_col;
                                    if (adv_wrap) begin
                                        idx_next       = COLS_IDX;
                                        copy_pend_next = 1'b0;
                                        state_next     = S_SCROLL;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                load_res   = 1'b1;
                state_next = S_IDLE;
            end
            S_DONE: begin
                load_res   = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL: begin
                // Read one cell ahead, write the cell read last cycle one row up.
                ram_raddr       = idx_reg;
                ram_we          = copy_pend_reg;
                ram_waddr       = copy_waddr_reg;
                ram_wdata       = ram_rdata;
                copy_pend_next  = 1'b1;
                copy_waddr_next = idx_reg - COLS_IDX;
                idx_next        = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                ram_we         = 1'b1;
                ram_waddr      = copy_waddr_reg;
                ram_wdata      = ram_rdata;
                copy_pend_next = 1'b0;
                idx_next       = LAST_ROW_IDX;
                state_next     = S_FILL;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = {def_attr_reg, BLANK_CHAR};
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result assembly from the already updated state.
    always_comb begin
        m_data_next                   = m_data_reg;
        m_valid_next                  = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_res) begin
            m_valid_next                  = 1'b1;
            m_data_next.cursor_row        = 5'(row_reg);
            m_data_next.cursor_col        = 7'(col_reg);
            m_data_next.cell_char         = rd_hit_reg ? ram_rdata[7:0] : 8'h00;
            m_data_next.cell_attr         = rd_hit_reg ? ram_rdata[15:8] : 8'h00;
            m_data_next.current_attribute = cur_attr_reg;
            m_data_next.position_error    = perr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Reset starts with the blanking sweep over the whole screen.
            state_reg     <= S_FILL;
            phase_reg     <= P_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            cur_attr_reg  <= RESET_ATTR;
            def_attr_reg  <= RESET_ATTR;
            pend_col_reg  <= '0;
            idx_reg       <= '0;
            copy_pend_reg <= 1'b0;
            init_reg      <= 1'b1;
            rd_hit_reg    <= 1'b0;
            perr_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cur_attr_reg  <= cur_attr_next;
            def_attr_reg  <= def_attr_next;
            pend_col_reg  <= pend_col_next;
            idx_reg       <= idx_next;
            copy_pend_reg <= copy_pend_next;
            init_reg      <= init_next;
            rd_hit_reg    <= rd_hit_next;
            perr_reg      <= perr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        copy_waddr_reg <= copy_waddr_next;
        m_data_reg     <= m_data_next;
    end

    // A result must never land on one that has not yet been taken.
    `TTS_ASSERT_NOW(a_no_result_overwrite, aclk, aresetn, load_res, !m_valid_reg || m_ready, "result register overwritten before transfer")

    // The cursor always names a cell on the screen.
    `TTS_ASSERT_NOW(a_cursor_on_screen, aclk, aresetn, 1'b1, (col_reg <= LAST_COL) && (row_reg <= LAST_ROW), "cursor off the screen")

    // While rows are copied up, the write never hits the cell being read.
    `TTS_ASSERT_NOW(a_scroll_no_collision, aclk, aresetn, (state_reg == S_SCROLL) && ram_we, ram_waddr != ram_raddr, "scroll write collides with read")

    // Every accepted item leads to a result load or a memory sweep next cycle.
    `TTS_ASSERT_NEXT(a_accept_progress, aclk, aresetn, accept, state_reg != S_IDLE, "accepted item left no work")

endmodule

/* hdl/tts_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
